[src/fac_pkg.sv]
// Package for the frame autocorrelation block.
// Holds result widths, status and register codes, and the cell control word.
// No dependencies.
`timescale 1ns / 1ps

package fac_pkg;

    localparam int ACC_W     = 44;
    localparam int LAG_IDX_W = 5;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_DW    = ((ACC_W + LAG_IDX_W + 7) / 8) * 8;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_LAGS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UNBIASED = 1'b1;

    typedef struct packed {
        logic take;     // a sample word enters the chain
        logic clr_d;    // the word closes the frame: empty the delay taps
        logic acc_en;   // registered product is ready to add
        logic shift;    // move accumulators one cell toward the head
        logic clear;    // zero all accumulators
    } t_cell_ctl;

endpackage

[src/fac_cell.sv]
// One lag cell: a delay tap, a registered product and a saturating accumulator.
// Depends on fac_pkg.
`timescale 1ns / 1ps

module fac_cell import fac_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cell_ctl                      i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_d,
    output logic signed [SAMPLE_WIDTH-1:0] o_d,
    input  logic signed [ACC_W-1:0]        i_acc,
    output logic signed [ACC_W-1:0]        o_acc
);

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

    logic signed [SAMPLE_WIDTH-1:0] r_d;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ACC_W-1:0]        n_acc;
    logic signed [SUM_W-1:0]        w_sum;

    assign w_sum = SUM_W'(r_acc) + SUM_W'(r_prod);

    always_comb begin
        if (w_sum > SUM_W'(ACC_MAX)) begin
            n_acc = ACC_MAX;
        end else if (w_sum < SUM_W'(ACC_MIN)) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_ctl.take) begin
            r_d <= i_ctl.clr_d ? '0 : i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_prod <= i_x * i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= i_acc;
        end else if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_d   = r_d;
    assign o_acc = r_acc;

endmodule

[src/fac_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Used for the unbiased lag scaling. Depends on fac_pkg.
`timescale 1ns / 1ps

module fac_div import fac_pkg::*; #(
    parameter int DIVIDEND_W = 57,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fit;

    assign w_trial = {r_rem, r_q[DIVIDEND_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits back in DIVISOR_W bits
            r_rem <= w_fit ? DIVISOR_W'(w_trial - {1'b0, r_div}) : w_trial[DIVISOR_W-1:0];
            r_q   <= {r_q[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[src/frame_autocorrelation.sv]
// Frame autocorrelation: chain of MAX_LAGS cells, one multiply-accumulate per cell per sample.
// Inside a frame one sample word is taken every cycle; after the closing word input stalls
// until all result words are loaded. The closing word leads to S_DRAIN, then per lag to
// S_LAG and S_EMIT, or to S_ERR for an error word; an unbiased lag of 1 or more adds S_DST
// and S_DIV, the bit-serial divider. Synchronous active-low reset clears the chain, sets
// num_lags 16, unbiased_mode 0. Uses fac_pkg, fac_cell, fac_div.
`timescale 1ns / 1ps

module frame_autocorrelation import fac_pkg::*; #(
    parameter int MAX_LAGS      = 32,
    parameter int MAX_FRAME_LEN = 4096,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_index,
    input  logic [CFG_W-1:0]                       i_cfg_wdata,
    // sample stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample
    input  logic                                   s_axis_tlast,  // last_sample
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [OUT_DW-1:0]                      m_axis_tdata,  // lag_index, lag_value
    output logic                                   m_axis_tlast,  // last_lag
    output logic [STATUS_W-1:0]                    m_axis_tuser   // status
);

    localparam int FLW    = $clog2(MAX_FRAME_LEN + 2);
    localparam int LCW    = $clog2(MAX_LAGS + 1);
    localparam int PW     = ACC_W + FLW;
    localparam int ST_W   = 3;

    localparam logic [ST_W-1:0] S_RUN   = 3'd0;
    localparam logic [ST_W-1:0] S_DRAIN = 3'd1;
    localparam logic [ST_W-1:0] S_ERR   = 3'd2;
    localparam logic [ST_W-1:0] S_LAG   = 3'd3;
    localparam logic [ST_W-1:0] S_DST   = 3'd4;
    localparam logic [ST_W-1:0] S_DIV   = 3'd5;
    localparam logic [ST_W-1:0] S_EMIT  = 3'd6;

    logic [CFG_W-1:0]        r_num_lags;
    logic                    r_unb_cfg;

    logic [ST_W-1:0]         r_state;
    logic [FLW-1:0]          r_len;
    logic [FLW-1:0]          w_len_next;
    logic [FLW-1:0]          r_n;
    logic [LCW-1:0]          r_lags;
    logic [LCW-1:0]          w_lags;
    logic                    r_unb;
    logic [STATUS_W-1:0]     r_status;
    logic [LCW-1:0]          r_k;
    logic                    r_pv;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_k_last;

    logic signed [SAMPLE_WIDTH-1:0] w_x;
    logic signed [SAMPLE_WIDTH-1:0] w_d   [0:MAX_LAGS];
    logic signed [ACC_W-1:0]        w_acc [0:MAX_LAGS];
    t_cell_ctl                      w_ctl;

    logic [ACC_W-1:0]        w_abs;
    logic [PW-1:0]           r_mprod;
    logic                    r_neg;
    logic signed [ACC_W-1:0] r_res;
    logic signed [ACC_W-1:0] w_scaled;

    logic                    w_div_start;
    logic                    w_div_busy;
    logic                    w_div_done;
    logic [PW-1:0]           w_quot;

    logic                    r_ov;
    logic [LAG_IDX_W-1:0]    r_oidx;
    logic signed [ACC_W-1:0] r_oval;
    logic                    r_olast;
    logic [STATUS_W-1:0]     r_ostat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lags <= CFG_W'(16);
            r_unb_cfg  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_NUM_LAGS: r_num_lags <= i_cfg_wdata;
                REG_UNBIASED: r_unb_cfg  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_RUN);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ov || m_axis_tready;
    assign w_x           = s_axis_tdata[SAMPLE_WIDTH-1:0];

    assign w_len_next = (r_len <= FLW'(MAX_FRAME_LEN)) ? r_len + 1'b1 : r_len;

    always_comb begin
        if (r_num_lags == '0) begin
            w_lags = LCW'(1);
        end else if (int'(r_num_lags) > MAX_LAGS) begin
            w_lags = LCW'(MAX_LAGS);
        end else begin
            w_lags = LCW'(r_num_lags);
        end
    end

    assign w_k_last = (r_k == r_lags - 1'b1);

    // cell chain: delay taps move away from the head, accumulators move toward it on unload
    assign w_ctl.take   = w_in_acc;
    assign w_ctl.clr_d  = s_axis_tlast;
    assign w_ctl.acc_en = r_pv;
    assign w_ctl.shift  = (r_state == S_EMIT) && w_out_free && !w_k_last;
    assign w_ctl.clear  = ((r_state == S_EMIT) && w_out_free && w_k_last)
                       || ((r_state == S_ERR) && w_out_free);

    assign w_d[0]          = w_x;
    assign w_acc[MAX_LAGS] = '0;

    for (genvar g = 0; g < MAX_LAGS; g++) begin : g_cell
        fac_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_x     (w_x),
            .i_d     (w_d[g]),
            .o_d     (w_d[g+1]),
            .i_acc   (w_acc[g+1]),
            .o_acc   (w_acc[g])
        );
    end

    // unbiased scaling: |r| * N, then divide by N - l
    assign w_abs       = w_acc[0][ACC_W-1] ? ACC_W'(-w_acc[0]) : ACC_W'(w_acc[0]);
    assign w_div_start = (r_state == S_DST);

    fac_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (FLW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mprod),
        .i_divisor  (r_n - FLW'(r_k)),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        if (r_neg) begin
            if ((|w_quot[PW-1:ACC_W]) || (w_quot[ACC_W-1] && (|w_quot[ACC_W-2:0]))) begin
                w_scaled = ACC_MIN;
            end else begin
                w_scaled = -$signed(w_quot[ACC_W-1:0]);
            end
        end else begin
            if (|w_quot[PW-1:ACC_W-1]) begin
                w_scaled = ACC_MAX;
            end else begin
                w_scaled = $signed(w_quot[ACC_W-1:0]);
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_len    <= '0;
            r_pv     <= 1'b0;
            r_k      <= '0;
            r_n      <= '0;
            r_lags   <= '0;
            r_unb    <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_pv <= w_in_acc;
            unique case (r_state)
                S_RUN: begin
                    if (w_in_acc) begin
                        if (s_axis_tlast) begin
                            r_len   <= '0;
                            r_n     <= w_len_next;
                            r_lags  <= w_lags;
                            r_unb   <= r_unb_cfg;
                            r_state <= S_DRAIN;
                            if (w_len_next > FLW'(MAX_FRAME_LEN)) begin
                                r_status <= ST_LONG;
                            end else if (int'(w_len_next) < int'(w_lags)) begin
                                r_status <= ST_SHORT;
                            end else begin
                                r_status <= ST_OK;
                            end
                        end else begin
                            r_len <= w_len_next;
                        end
                    end
                end
                S_DRAIN: begin
                    r_k     <= '0;
                    r_state <= (r_status == ST_OK) ? S_LAG : S_ERR;
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_state <= S_RUN;
                    end
                end
                S_LAG: begin
                    r_state <= (r_unb && r_k != '0) ? S_DST : S_EMIT;
                end
                S_DST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (w_k_last) begin
                            r_state <= S_RUN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_LAG;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    // head value path
    always_ff @(posedge i_clk) begin
        if (r_state == S_LAG) begin
            r_mprod <= PW'(w_abs) * PW'(r_n);
            r_neg   <= w_acc[0][ACC_W-1];
            r_res   <= w_acc[0];
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_res <= w_scaled;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (((r_state == S_EMIT) || (r_state == S_ERR)) && w_out_free) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_oidx  <= LAG_IDX_W'(r_k);
            r_oval  <= r_res;
            r_olast <= w_k_last;
            r_ostat <= ST_OK;
        end else if ((r_state == S_ERR) && w_out_free) begin
            r_oidx  <= '0;
            r_oval  <= '0;
            r_olast <= 1'b1;
            r_ostat <= r_status;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_DW-ACC_W-LAG_IDX_W){1'b0}}, r_oval, r_oidx};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ostat;

    // checks
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> (r_state == S_DRAIN))
        else $error("closing word did not start the drain");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAG || r_state == S_ERR) |-> !r_pv)
        else $error("unload began with a product still in flight");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k < r_lags))
        else $error("lag counter beyond lag count");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast)
        else $error("error word not marked last");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for frame_autocorrelation: directed table, full-scale frame, random frames.
// Predicts lag words from its integer model or a typed row, and compares them field by field.
// Depends on fac_pkg and the frame_autocorrelation RTL.
`timescale 1ns / 1ps

module tb_top;
    import fac_pkg::*;

    localparam int MAX_LAGS      = 32;
    localparam int MAX_FRAME_LEN = 4096;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_TYPED} t_row_kind;
    typedef enum logic [1:0] {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} t_pace;

    typedef struct packed {
        logic [LAG_IDX_W-1:0]    lag;
        logic signed [ACC_W-1:0] value;
        logic                    last;
        logic [STATUS_W-1:0]     status;
    } t_lag_word;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_W-1:0]        reg_val;
        logic [15:0]             sample;
        logic                    last;
        logic signed [ACC_W-1:0] lag_val;   // typed rows: single word, lag 0, last set
        logic [STATUS_W-1:0]     status;
    } t_stim_row;

    localparam int NUM_ROWS = 23;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        // reset setting is 16 lags: one sample is a short frame
        '{ROW_TYPED, REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b1, 44'sd0, ST_SHORT},
        '{ROW_CFG,   REG_NUM_LAGS, 6'd2,  16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_CFG,   REG_UNBIASED, 6'd1,  16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h8000, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h8000, 1'b1, 44'sd0, ST_OK},
        // zero lags acts as one lag
        '{ROW_CFG,   REG_NUM_LAGS, 6'd0,  16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_TYPED, REG_NUM_LAGS, 6'd0,  16'h8000, 1'b1, 44'sd1073741824, ST_OK},
        '{ROW_TYPED, REG_NUM_LAGS, 6'd0,  16'h0000, 1'b1, 44'sd0, ST_OK},
        '{ROW_CFG,   REG_UNBIASED, 6'd0,  16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_CFG,   REG_NUM_LAGS, 6'd4,  16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b1, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h0001, 1'b0, 44'sd0, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h0002, 1'b0, 44'sd0, ST_OK},
        '{ROW_TYPED, REG_NUM_LAGS, 6'd0,  16'hFFFF, 1'b1, 44'sd0, ST_SHORT},
        // above the lag limit acts as 32 lags
        '{ROW_CFG,   REG_NUM_LAGS, 6'd63, 16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_TYPED, REG_NUM_LAGS, 6'd0,  16'h8000, 1'b1, 44'sd0, ST_SHORT},
        '{ROW_CFG,   REG_NUM_LAGS, 6'd1,  16'h0000, 1'b0, 44'sd0, ST_OK},
        '{ROW_TYPED, REG_NUM_LAGS, 6'd0,  16'h7FFF, 1'b1, 44'sd1073676289, ST_OK},
        '{ROW_WORD,  REG_NUM_LAGS, 6'd0,  16'h5A5A, 1'b1, 44'sd0, ST_OK}
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_DW-1:0]      m_axis_tdata;
    logic                   m_axis_tlast;
    logic [STATUS_W-1:0]    m_axis_tuser;

    // predictor state and register copies
    longint           taps [MAX_LAGS];
    longint           sums [MAX_LAGS];
    int               frame_len    = 0;
    logic [CFG_W-1:0] lags_reg     = 6'd16;
    bit               unbiased_reg = 1'b0;

    t_lag_word lag_words_due [$];
    int        error_count = 0;
    int        quiet_cycles = 0;
    t_pace     pace = PACE_FULL;

    frame_autocorrelation uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sample
        .s_axis_tlast  (s_axis_tlast),   // last_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // lag_index, lag_value
        .m_axis_tlast  (m_axis_tlast),   // last_lag
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat44(input longint v);
        if (v > longint'(ACC_MAX)) return longint'(ACC_MAX);
        if (v < longint'(ACC_MIN)) return longint'(ACC_MIN);
        return v;
    endfunction

    function automatic int lags_in_use();
        if (lags_reg == 0) return 1;
        if (lags_reg > MAX_LAGS) return MAX_LAGS;
        return int'(lags_reg);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Advance the lag sums by one sample; on the closing sample queue the lag words if queue_words is set.
    task automatic autocorr_take_word(input logic [15:0] raw, input logic last,
                                      input bit queue_words);
        longint    x;
        longint    v;
        int        lags;
        t_lag_word w;
        x = longint'($signed(raw));
        sums[0] = sat44(sums[0] + x * x);
        for (int l = 1; l < MAX_LAGS; l++)
            sums[l] = sat44(sums[l] + x * taps[l-1]);
        for (int l = MAX_LAGS - 1; l > 0; l--)
            taps[l] = taps[l-1];
        taps[0] = x;
        if (frame_len <= MAX_FRAME_LEN)
            frame_len++;
        if (last) begin
            lags = lags_in_use();
            if (frame_len > MAX_FRAME_LEN || frame_len < lags) begin
                w = '{'0, '0, 1'b1, (frame_len > MAX_FRAME_LEN) ? ST_LONG : ST_SHORT};
                if (queue_words)
                    lag_words_due.push_back(w);
            end else begin
                for (int l = 0; l < lags; l++) begin
                    v = sums[l];
                    if (unbiased_reg && l >= 1)
                        v = sat44((v * frame_len) / (frame_len - l));
                    w = '{LAG_IDX_W'(l), v[ACC_W-1:0], (l + 1 == lags), ST_OK};
                    if (queue_words)
                        lag_words_due.push_back(w);
                end
            end
            for (int l = 0; l < MAX_LAGS; l++) begin
                taps[l] = 0;
                sums[l] = 0;
            end
            frame_len = 0;
        end
    endtask

    task automatic send_word(input logic [15:0] sample, input logic last, input bit queue_words);
        int gap_pct;
        gap_pct = (pace == PACE_SEND_GAPS) ? 53 : (pace == PACE_BOTH) ? 13 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        autocorr_take_word(sample, last, queue_words);
    endtask

    // Hold the sample side idle until every lag word is back, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (lag_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_NUM_LAGS)
            lags_reg = val;
        else
            unbiased_reg = val[0];
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        int stall_pct;
        stall_pct = (pace == PACE_RECV_STALLS) ? 53 : (pace == PACE_BOTH) ? 13 : 0;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : check_lag_words
        t_lag_word due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (lag_words_due.size() == 0) begin
                report_mismatch("lag word with none expected");
            end else begin
                due = lag_words_due.pop_front();
                if (m_axis_tdata[LAG_IDX_W-1:0] != due.lag)
                    report_mismatch($sformatf("lag_index %0d, expected %0d",
                                    m_axis_tdata[LAG_IDX_W-1:0], due.lag));
                if ($signed(m_axis_tdata[LAG_IDX_W +: ACC_W]) != due.value)
                    report_mismatch($sformatf("lag %0d value %0d, expected %0d", due.lag,
                                    $signed(m_axis_tdata[LAG_IDX_W +: ACC_W]), due.value));
                if (m_axis_tlast != due.last)
                    report_mismatch($sformatf("lag %0d last %0b, expected %0b", due.lag,
                                    m_axis_tlast, due.last));
                if (m_axis_tuser != due.status)
                    report_mismatch($sformatf("lag %0d status %0d, expected %0d", due.lag,
                                    m_axis_tuser, due.status));
            end
        end
    end

    // End the run when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int        eff;
        int        len;
        int        sent;
        t_stim_row row;
        for (int l = 0; l < MAX_LAGS; l++) begin
            taps[l] = 0;
            sums[l] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_word(row.sample, row.last, row.kind == ROW_WORD);
                if (row.kind == ROW_TYPED)
                    lag_words_due.push_back(t_lag_word'{'0, row.lag_val, 1'b1, row.status});
            end
        end

        // full-scale frame exactly as long as the lag limit, every lag above 0 scaled
        drain();
        write_reg(REG_NUM_LAGS, 6'd32);
        write_reg(REG_UNBIASED, 6'd1);
        for (int k = 0; k < MAX_LAGS; k++)
            send_word(16'h8000, k == MAX_LAGS - 1, 1'b1);

        for (int m = 0; m < 4; m++) begin
            for (int s = 0; s < 2; s++) begin
                drain();
                pace = t_pace'(m);
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_NUM_LAGS, 6'd0);
                    1:       write_reg(REG_NUM_LAGS, 6'd32);
                    2:       write_reg(REG_NUM_LAGS, 6'($urandom_range(0, 63)));
                    default: write_reg(REG_NUM_LAGS, 6'($urandom_range(1, 12)));
                endcase
                write_reg(REG_UNBIASED, 6'($urandom_range(0, 1)));
                eff  = lags_in_use();
                sent = 0;
                while (sent < 10) begin
                    // mostly complete frames, some cut short of the lag count
                    if ($urandom_range(0, 9) < 2)
                        len = (eff > 1) ? $urandom_range(1, eff - 1) : $urandom_range(1, 3);
                    else
                        len = $urandom_range(eff, eff + 10);
                    for (int k = 0; k < len; k++)
                        send_word(pick_sample(), k == len - 1, 1'b1);
                    sent += len;
                end
            end
        end

        drain();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
